[rtl/core/cbkt_pkg.sv]
// Shared constants, register codes and helpers for the color blob k-means tracker.
// Used by every module of the core but the divider; depends on nothing.
`default_nettype none

package cbkt_pkg;

	localparam int MAX_POINTS_DEF   = 4096;
	localparam int NUM_CLUSTERS_DEF = 2;
	localparam int FRAME_WIDTH_DEF  = 1024;
	localparam int FRAME_HEIGHT_DEF = 768;
	localparam int ROUNDS_DEF       = 11;

	localparam int PIX_W       = 8;
	localparam int CFG_AW      = 5;
	localparam int CFG_DW      = 32;
	localparam int OUT_COORD_W = 10;
	localparam int MEAN_INIT   = 400;
	localparam int GATE_LIMIT  = 5;
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [2:0] {
		REG_HUE_LOW  = 3'd0,
		REG_HUE_HIGH = 3'd1,
		REG_SAT_LOW  = 3'd2,
		REG_SAT_HIGH = 3'd3,
		REG_VAL_LOW  = 3'd4,
		REG_VAL_HIGH = 3'd5
	} reg_idx_t;

	localparam logic [PIX_W-1:0] HUE_LOW_RST  = 8'd141;
	localparam logic [PIX_W-1:0] HUE_HIGH_RST = 8'd186;
	localparam logic [PIX_W-1:0] SAT_LOW_RST  = 8'd34;
	localparam logic [PIX_W-1:0] SAT_HIGH_RST = 8'd255;
	localparam logic [PIX_W-1:0] VAL_LOW_RST  = 8'd131;
	localparam logic [PIX_W-1:0] VAL_HIGH_RST = 8'd255;

	typedef struct packed {
		logic [PIX_W-1:0] hue_low;
		logic [PIX_W-1:0] hue_high;
		logic [PIX_W-1:0] sat_low;
		logic [PIX_W-1:0] sat_high;
		logic [PIX_W-1:0] val_low;
		logic [PIX_W-1:0] val_high;
	} thr_t;

	function automatic logic in_window(logic [PIX_W-1:0] c, logic [PIX_W-1:0] lo,
		logic [PIX_W-1:0] hi);
		return (c >= lo) && (c <= hi);
	endfunction

endpackage

`default_nettype wire

[rtl/core/cbkt_front.sv]
// Front end: threshold registers on the APB port, pixel classification and raster counters.
// Depends on cbkt_pkg.
`default_nettype none

module cbkt_front #(
	parameter int FRAME_WIDTH  = cbkt_pkg::FRAME_WIDTH_DEF,
	parameter int FRAME_HEIGHT = cbkt_pkg::FRAME_HEIGHT_DEF,
	parameter int XW           = 10,
	parameter int YW           = 10
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [cbkt_pkg::CFG_AW-1:0]    paddr,
	input  wire logic [cbkt_pkg::CFG_DW-1:0]    pwdata,
	output logic      [cbkt_pkg::CFG_DW-1:0]    prdata,
	output logic                                pready,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [cbkt_pkg::PIX_W-1:0]     pixel_hue,
	input  wire logic [cbkt_pkg::PIX_W-1:0]     pixel_sat,
	input  wire logic [cbkt_pkg::PIX_W-1:0]     pixel_val,
	input  wire logic                           frame_end,
	input  wire logic                           q_full,
	output logic                                q_push,
	output logic                                ent_match,
	output logic      [XW-1:0]                  ent_col,
	output logic      [YW-1:0]                  ent_row,
	output logic                                ent_last
);

	cbkt_pkg::thr_t         thr_q;
	logic [XW-1:0]          col_q;
	logic [YW-1:0]          row_q;
	logic                   accept;
	logic                   match;
	logic                   wr_en;
	cbkt_pkg::reg_idx_t     widx;
	logic [cbkt_pkg::PIX_W-1:0] rd_val;

	assign pready   = 1'b1;
	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	assign match = cbkt_pkg::in_window(pixel_hue, thr_q.hue_low, thr_q.hue_high) &&
		cbkt_pkg::in_window(pixel_sat, thr_q.sat_low, thr_q.sat_high) &&
		cbkt_pkg::in_window(pixel_val, thr_q.val_low, thr_q.val_high);

	assign q_push    = accept && (match || frame_end);
	assign ent_match = match;
	assign ent_col   = col_q;
	assign ent_row   = row_q;
	assign ent_last  = frame_end;

	assign wr_en = psel && penable && pwrite && pready;
	assign widx  = cbkt_pkg::reg_idx_t'(paddr[4:2]);

	always_comb begin
		unique case (widx)
			cbkt_pkg::REG_HUE_LOW:  rd_val = thr_q.hue_low;
			cbkt_pkg::REG_HUE_HIGH: rd_val = thr_q.hue_high;
			cbkt_pkg::REG_SAT_LOW:  rd_val = thr_q.sat_low;
			cbkt_pkg::REG_SAT_HIGH: rd_val = thr_q.sat_high;
			cbkt_pkg::REG_VAL_LOW:  rd_val = thr_q.val_low;
			cbkt_pkg::REG_VAL_HIGH: rd_val = thr_q.val_high;
			default:                rd_val = '0;
		endcase
	end

	assign prdata = {{(cbkt_pkg::CFG_DW - cbkt_pkg::PIX_W){1'b0}}, rd_val};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q.hue_low  <= cbkt_pkg::HUE_LOW_RST;
			thr_q.hue_high <= cbkt_pkg::HUE_HIGH_RST;
			thr_q.sat_low  <= cbkt_pkg::SAT_LOW_RST;
			thr_q.sat_high <= cbkt_pkg::SAT_HIGH_RST;
			thr_q.val_low  <= cbkt_pkg::VAL_LOW_RST;
			thr_q.val_high <= cbkt_pkg::VAL_HIGH_RST;
		end else if (wr_en) begin
			unique case (widx)
				cbkt_pkg::REG_HUE_LOW:  thr_q.hue_low  <= pwdata[cbkt_pkg::PIX_W-1:0];
				cbkt_pkg::REG_HUE_HIGH: thr_q.hue_high <= pwdata[cbkt_pkg::PIX_W-1:0];
				cbkt_pkg::REG_SAT_LOW:  thr_q.sat_low  <= pwdata[cbkt_pkg::PIX_W-1:0];
				cbkt_pkg::REG_SAT_HIGH: thr_q.sat_high <= pwdata[cbkt_pkg::PIX_W-1:0];
				cbkt_pkg::REG_VAL_LOW:  thr_q.val_low  <= pwdata[cbkt_pkg::PIX_W-1:0];
				cbkt_pkg::REG_VAL_HIGH: thr_q.val_high <= pwdata[cbkt_pkg::PIX_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (frame_end) begin
				col_q <= '0;
				row_q <= '0;
			end else if (col_q == XW'(FRAME_WIDTH - 1)) begin
				col_q <= '0;
				row_q <= (row_q == YW'(FRAME_HEIGHT - 1)) ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/core/cbkt_fifo.sv]
// Short transfer queue between the front end and the clustering back end.
// Depends on cbkt_pkg for its depth.
`default_nettype none

module cbkt_fifo #(
	parameter int W = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] wdata,
	input  wire logic         pop,
	output logic      [W-1:0] rdata,
	output logic              full,
	output logic              empty
);

	localparam int D  = cbkt_pkg::QUEUE_DEPTH;
	localparam int PW = $clog2(D);
	localparam int CW = $clog2(D + 1);

	logic [W-1:0]  buf_q [D];
	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic [CW-1:0] cnt_q;

	assign full  = (cnt_q == CW'(D));
	assign empty = (cnt_q == '0);
	assign rdata = buf_q[rp_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			buf_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop && !empty) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + CW'(push && !full) - CW'(pop && !empty);
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |=> (cnt_q == CW'(D)) || $past(pop))
		else $error("queue count dropped without a pop");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(D))
		else $error("queue count beyond depth");
	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(empty && !push) |=> empty)
		else $error("queue filled without a push");

endmodule

`default_nettype wire

[rtl/core/cbkt_div.sv]
// Restoring divider, one quotient bit per cycle, for cluster mean computation.
// Depends on nothing beyond its parameters.
`default_nettype none

module cbkt_div #(
	parameter int SW = 24,
	parameter int NW = 13
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [SW-1:0] dividend,
	input  wire logic [NW-1:0] divisor,
	output logic               done,
	output logic      [SW-1:0] quotient
);

	localparam int KW = $clog2(SW + 1);

	logic [NW-1:0] rem_q;
	logic [SW-1:0] quo_q;
	logic [NW-1:0] dvs_q;
	logic [KW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [NW:0]   shifted;
	logic          take;

	assign shifted  = {rem_q, quo_q[SW-1]};
	assign take     = shifted >= {1'b0, dvs_q};
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= KW'(SW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == KW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= take ? NW'(shifted - {1'b0, dvs_q}) : shifted[NW-1:0];
			quo_q <= {quo_q[SW-2:0], take};
		end
	end

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider restarted while busy");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("divider done without work");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("divider done held");

endmodule

`default_nettype wire

[rtl/core/cbkt_back.sv]
// Back end: point store, k-means rounds, centroid gating and result output register.
// Depends on cbkt_pkg and cbkt_div.
`default_nettype none

module cbkt_back #(
	parameter int MAX_POINTS   = cbkt_pkg::MAX_POINTS_DEF,
	parameter int NUM_CLUSTERS = cbkt_pkg::NUM_CLUSTERS_DEF,
	parameter int ROUNDS       = cbkt_pkg::ROUNDS_DEF,
	parameter int XW           = 10,
	parameter int YW           = 10
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          q_empty,
	output logic               q_pop,
	input  wire logic          ent_match,
	input  wire logic [XW-1:0] ent_col,
	input  wire logic [YW-1:0] ent_row,
	input  wire logic          ent_last,
	output logic               out_valid,
	input  wire logic          out_stall,
	output logic               cluster_index,
	output logic [cbkt_pkg::OUT_COORD_W-1:0] centroid_x,
	output logic [cbkt_pkg::OUT_COORD_W-1:0] centroid_y,
	output logic               tracked,
	output logic               overflowed,
	output logic               last_result
);

	localparam int K   = NUM_CLUSTERS;
	localparam int AW  = $clog2(MAX_POINTS);
	localparam int NW  = $clog2(MAX_POINTS + 1);
	localparam int CLW = $clog2(K);
	localparam int RW  = $clog2(ROUNDS + 1);
	localparam int MW  = (XW > YW) ? XW : YW;
	localparam int SW  = MW + NW;
	localparam int DW  = 2 * MW + 1;
	localparam int OW  = cbkt_pkg::OUT_COORD_W;

	typedef enum logic [3:0] {
		B_IDLE, B_INIT, B_SUM_RD, B_SUM_ACC, B_DIV_START, B_DIV_WAIT,
		B_ASG_RD, B_ASG_DIFF, B_ASG_SQ, B_ASG_CMP, B_GATE, B_EMIT
	} bstate_t;

	bstate_t state_q;

	logic [XW-1:0]  col_mem [MAX_POINTS];
	logic [YW-1:0]  row_mem [MAX_POINTS];
	logic [CLW-1:0] clu_mem [MAX_POINTS];
	logic [XW-1:0]  rd_col_q;
	logic [YW-1:0]  rd_row_q;
	logic [CLW-1:0] rd_clu_q;

	logic [NW-1:0]  count_q;
	logic [NW-1:0]  idx_q;
	logic           ovf_q;
	logic           trk_q;
	logic [CLW-1:0] modk_q;
	logic [CLW-1:0] jj_q;
	logic [RW-1:0]  round_q;
	logic           axis_q;

	logic [SW-1:0]  acc_x_q [K];
	logic [SW-1:0]  acc_y_q [K];
	logic [NW-1:0]  n_q     [K];
	logic [XW-1:0]  mean_x_q [K];
	logic [YW-1:0]  mean_y_q [K];
	logic [XW-1:0]  prev_x_q [K];
	logic [YW-1:0]  prev_y_q [K];
	logic [XW-1:0]  held_x_q [K];
	logic [YW-1:0]  held_y_q [K];

	logic [MW-1:0]  dx_s1;
	logic [MW-1:0]  dy_s1;
	logic [DW-1:0]  d_s2;
	logic [DW-1:0]  best_q;
	logic [CLW-1:0] bj_q;
	logic           better;
	logic [CLW-1:0] bj_next;

	logic           store_ok;
	logic           wr_pt;
	logic [NW-1:0]  cnt_next;
	logic           wr_clu;
	logic [CLW-1:0] clu_wdata;
	logic           last_pt;

	logic           div_start;
	logic [SW-1:0]  div_dividend;
	logic           div_done;
	logic [SW-1:0]  div_quo;

	logic           close [K];

	logic           o_valid_q;
	logic [CLW-1:0] o_j_q;
	logic           o_idx_q;
	logic [OW-1:0]  o_x_q;
	logic [OW-1:0]  o_y_q;
	logic           o_trk_q;
	logic           o_ovf_q;
	logic           o_last_q;

	assign q_pop    = (state_q == B_IDLE) && !q_empty;
	assign store_ok = count_q < NW'(MAX_POINTS);
	assign wr_pt    = q_pop && ent_match && store_ok;
	assign cnt_next = count_q + NW'(wr_pt);
	assign last_pt  = (idx_q == count_q - 1'b1);

	assign better  = (jj_q == '0) || (d_s2 < best_q);
	assign bj_next = better ? jj_q : bj_q;

	assign wr_clu    = (state_q == B_INIT) ||
		((state_q == B_ASG_CMP) && (jj_q == CLW'(K - 1)));
	assign clu_wdata = (state_q == B_INIT) ? modk_q : bj_next;

	assign div_start    = (state_q == B_DIV_START) && (n_q[jj_q] != '0);
	assign div_dividend = axis_q ? acc_y_q[jj_q] : acc_x_q[jj_q];

	cbkt_div #(.SW(SW), .NW(NW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (n_q[jj_q]),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_comb begin
		for (int j = 0; j < K; j++) begin
			close[j] = ((mean_x_q[j] > prev_x_q[j]) ? (mean_x_q[j] - prev_x_q[j]) :
				(prev_x_q[j] - mean_x_q[j])) < XW'(cbkt_pkg::GATE_LIMIT) &&
				((mean_y_q[j] > prev_y_q[j]) ? (mean_y_q[j] - prev_y_q[j]) :
				(prev_y_q[j] - mean_y_q[j])) < YW'(cbkt_pkg::GATE_LIMIT);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_pt) begin
			col_mem[count_q[AW-1:0]] <= ent_col;
			row_mem[count_q[AW-1:0]] <= ent_row;
		end
		if (wr_clu) begin
			clu_mem[idx_q[AW-1:0]] <= clu_wdata;
		end
		rd_col_q <= col_mem[idx_q[AW-1:0]];
		rd_row_q <= row_mem[idx_q[AW-1:0]];
		rd_clu_q <= clu_mem[idx_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (state_q == B_ASG_DIFF) begin
			dx_s1 <= MW'((rd_col_q > mean_x_q[jj_q]) ? (rd_col_q - mean_x_q[jj_q]) :
				(mean_x_q[jj_q] - rd_col_q));
			dy_s1 <= MW'((rd_row_q > mean_y_q[jj_q]) ? (rd_row_q - mean_y_q[jj_q]) :
				(mean_y_q[jj_q] - rd_row_q));
		end
		if (state_q == B_ASG_SQ) begin
			d_s2 <= DW'(dx_s1 * dx_s1) + DW'(dy_s1 * dy_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			count_q   <= '0;
			idx_q     <= '0;
			ovf_q     <= 1'b0;
			trk_q     <= 1'b0;
			modk_q    <= '0;
			jj_q      <= '0;
			round_q   <= '0;
			axis_q    <= 1'b0;
			best_q    <= '0;
			bj_q      <= '0;
			o_valid_q <= 1'b0;
			o_j_q     <= '0;
			o_idx_q   <= 1'b0;
			o_x_q     <= '0;
			o_y_q     <= '0;
			o_trk_q   <= 1'b0;
			o_ovf_q   <= 1'b0;
			o_last_q  <= 1'b0;
			for (int j = 0; j < K; j++) begin
				acc_x_q[j]  <= '0;
				acc_y_q[j]  <= '0;
				n_q[j]      <= '0;
				mean_x_q[j] <= XW'(cbkt_pkg::MEAN_INIT);
				mean_y_q[j] <= YW'(cbkt_pkg::MEAN_INIT);
				prev_x_q[j] <= XW'(cbkt_pkg::MEAN_INIT);
				prev_y_q[j] <= YW'(cbkt_pkg::MEAN_INIT);
				held_x_q[j] <= XW'(cbkt_pkg::MEAN_INIT);
				held_y_q[j] <= YW'(cbkt_pkg::MEAN_INIT);
			end
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (q_pop) begin
						count_q <= cnt_next;
						if (ent_match && !store_ok) begin
							ovf_q <= 1'b1;
						end
						if (ent_last) begin
							trk_q  <= cnt_next >= NW'(K);
							idx_q  <= '0;
							modk_q <= '0;
							o_j_q  <= '0;
							state_q <= (cnt_next >= NW'(K)) ? B_INIT : B_EMIT;
						end
					end
				end
				B_INIT: begin
					modk_q <= (modk_q == CLW'(K - 1)) ? '0 : modk_q + 1'b1;
					if (last_pt) begin
						idx_q   <= '0;
						round_q <= '0;
						for (int j = 0; j < K; j++) begin
							acc_x_q[j] <= '0;
							acc_y_q[j] <= '0;
							n_q[j]     <= '0;
						end
						state_q <= B_SUM_RD;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				B_SUM_RD: begin
					state_q <= B_SUM_ACC;
				end
				B_SUM_ACC: begin
					acc_x_q[rd_clu_q] <= acc_x_q[rd_clu_q] + SW'(rd_col_q);
					acc_y_q[rd_clu_q] <= acc_y_q[rd_clu_q] + SW'(rd_row_q);
					n_q[rd_clu_q]     <= n_q[rd_clu_q] + 1'b1;
					if (last_pt) begin
						jj_q    <= '0;
						axis_q  <= 1'b0;
						state_q <= B_DIV_START;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= B_SUM_RD;
					end
				end
				B_DIV_START: begin
					if (n_q[jj_q] != '0) begin
						state_q <= B_DIV_WAIT;
					end else if (jj_q == CLW'(K - 1)) begin
						jj_q    <= '0;
						idx_q   <= '0;
						state_q <= B_ASG_RD;
					end else begin
						jj_q <= jj_q + 1'b1;
					end
				end
				B_DIV_WAIT: begin
					if (div_done) begin
						if (!axis_q) begin
							mean_x_q[jj_q] <= div_quo[XW-1:0];
							axis_q         <= 1'b1;
							state_q        <= B_DIV_START;
						end else begin
							mean_y_q[jj_q] <= div_quo[YW-1:0];
							axis_q         <= 1'b0;
							if (jj_q == CLW'(K - 1)) begin
								jj_q    <= '0;
								idx_q   <= '0;
								state_q <= B_ASG_RD;
							end else begin
								jj_q    <= jj_q + 1'b1;
								state_q <= B_DIV_START;
							end
						end
					end
				end
				B_ASG_RD: begin
					state_q <= B_ASG_DIFF;
				end
				B_ASG_DIFF: begin
					state_q <= B_ASG_SQ;
				end
				B_ASG_SQ: begin
					state_q <= B_ASG_CMP;
				end
				B_ASG_CMP: begin
					if (better) begin
						best_q <= d_s2;
					end
					bj_q <= bj_next;
					if (jj_q != CLW'(K - 1)) begin
						jj_q    <= jj_q + 1'b1;
						state_q <= B_ASG_DIFF;
					end else begin
						jj_q <= '0;
						if (!last_pt) begin
							idx_q   <= idx_q + 1'b1;
							state_q <= B_ASG_RD;
						end else if (round_q == RW'(ROUNDS - 1)) begin
							state_q <= B_GATE;
						end else begin
							round_q <= round_q + 1'b1;
							idx_q   <= '0;
							for (int j = 0; j < K; j++) begin
								acc_x_q[j] <= '0;
								acc_y_q[j] <= '0;
								n_q[j]     <= '0;
							end
							state_q <= B_SUM_RD;
						end
					end
				end
				B_GATE: begin
					for (int j = 0; j < K; j++) begin
						held_x_q[j] <= close[j] ? mean_x_q[j] : prev_x_q[j];
						held_y_q[j] <= close[j] ? mean_y_q[j] : prev_y_q[j];
						prev_x_q[j] <= mean_x_q[j];
						prev_y_q[j] <= mean_y_q[j];
					end
					o_j_q   <= '0;
					state_q <= B_EMIT;
				end
				B_EMIT: begin
					if (!o_valid_q) begin
						o_valid_q <= 1'b1;
						o_idx_q   <= o_j_q[0];
						o_x_q     <= held_x_q[o_j_q][OW-1:0];
						o_y_q     <= held_y_q[o_j_q][OW-1:0];
						o_trk_q   <= trk_q;
						o_ovf_q   <= ovf_q;
						o_last_q  <= (o_j_q == CLW'(K - 1));
					end else if (!out_stall) begin
						o_valid_q <= 1'b0;
						if (o_j_q == CLW'(K - 1)) begin
							count_q <= '0;
							ovf_q   <= 1'b0;
							state_q <= B_IDLE;
						end else begin
							o_j_q <= o_j_q + 1'b1;
						end
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	assign out_valid     = o_valid_q;
	assign cluster_index = o_idx_q;
	assign centroid_x    = o_x_q;
	assign centroid_y    = o_y_q;
	assign tracked       = o_trk_q;
	assign overflowed    = o_ovf_q;
	assign last_result   = o_last_q;

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= NW'(MAX_POINTS))
		else $error("point count beyond store capacity");
	a_out_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		o_valid_q |-> (state_q == B_EMIT))
		else $error("result valid outside output phase");
	a_sum_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_SUM_ACC) |-> (idx_q < count_q))
		else $error("accumulation past stored points");
	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != B_IDLE) |-> !q_pop)
		else $error("queue popped while clustering");

endmodule

`default_nettype wire

[rtl/core/color_blob_kmeans_tracker_core.sv]
// Color blob tracker top: pixels are taken one per cycle while the queue has room.
// A frame end with at least K stored points starts the clustering pass, whose length for N
// stored points and sum width SW is set by the single memory read port and the divider.
// Then K results are emitted one at a time, each held while the output stalls.
// Reset clears control, restores thresholds and sets every mean to 400; the point store is
// not cleared, only entries of the current frame are read. Depends on cbkt_pkg and submodules.
`default_nettype none

module color_blob_kmeans_tracker_core #(
	parameter int MAX_POINTS   = cbkt_pkg::MAX_POINTS_DEF,
	parameter int NUM_CLUSTERS = cbkt_pkg::NUM_CLUSTERS_DEF,
	parameter int FRAME_WIDTH  = cbkt_pkg::FRAME_WIDTH_DEF,
	parameter int FRAME_HEIGHT = cbkt_pkg::FRAME_HEIGHT_DEF,
	parameter int ROUNDS       = cbkt_pkg::ROUNDS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [cbkt_pkg::CFG_AW-1:0]         paddr,
	input  wire logic [cbkt_pkg::CFG_DW-1:0]         pwdata,
	output logic      [cbkt_pkg::CFG_DW-1:0]         prdata,
	output logic                                     pready,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [cbkt_pkg::PIX_W-1:0]          pixel_hue,
	input  wire logic [cbkt_pkg::PIX_W-1:0]          pixel_sat,
	input  wire logic [cbkt_pkg::PIX_W-1:0]          pixel_val,
	input  wire logic                                frame_end,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic                                     cluster_index,
	output logic      [cbkt_pkg::OUT_COORD_W-1:0]    centroid_x,
	output logic      [cbkt_pkg::OUT_COORD_W-1:0]    centroid_y,
	output logic                                     tracked,
	output logic                                     overflowed,
	output logic                                     last_result
);

	localparam int XW = ($clog2(FRAME_WIDTH) > cbkt_pkg::OUT_COORD_W) ?
		$clog2(FRAME_WIDTH) : cbkt_pkg::OUT_COORD_W;
	localparam int YW = ($clog2(FRAME_HEIGHT) > cbkt_pkg::OUT_COORD_W) ?
		$clog2(FRAME_HEIGHT) : cbkt_pkg::OUT_COORD_W;
	localparam int EW = XW + YW + 2;

	logic          q_push;
	logic          q_pop;
	logic          q_full;
	logic          q_empty;
	logic          f_match;
	logic [XW-1:0] f_col;
	logic [YW-1:0] f_row;
	logic          f_last;
	logic [EW-1:0] q_rdata;

	cbkt_front #(
		.FRAME_WIDTH  (FRAME_WIDTH),
		.FRAME_HEIGHT (FRAME_HEIGHT),
		.XW           (XW),
		.YW           (YW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.pixel_hue (pixel_hue),
		.pixel_sat (pixel_sat),
		.pixel_val (pixel_val),
		.frame_end (frame_end),
		.q_full    (q_full),
		.q_push    (q_push),
		.ent_match (f_match),
		.ent_col   (f_col),
		.ent_row   (f_row),
		.ent_last  (f_last)
	);

	cbkt_fifo #(.W(EW)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  ({f_match, f_last, f_col, f_row}),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	cbkt_back #(
		.MAX_POINTS   (MAX_POINTS),
		.NUM_CLUSTERS (NUM_CLUSTERS),
		.ROUNDS       (ROUNDS),
		.XW           (XW),
		.YW           (YW)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_pop         (q_pop),
		.ent_match     (q_rdata[EW-1]),
		.ent_last      (q_rdata[EW-2]),
		.ent_col       (q_rdata[YW +: XW]),
		.ent_row       (q_rdata[YW-1:0]),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.cluster_index (cluster_index),
		.centroid_x    (centroid_x),
		.centroid_y    (centroid_y),
		.tracked       (tracked),
		.overflowed    (overflowed),
		.last_result   (last_result)
	);

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for color_blob_kmeans_tracker_core: drives HSV pixel frames and
// APB threshold writes, predicts the gated k-means centroids of each frame and checks them.
// Depends on cbkt_pkg and the core RTL.
`default_nettype none

module tb;

	localparam int K      = cbkt_pkg::NUM_CLUSTERS_DEF;
	localparam int NPTS   = cbkt_pkg::MAX_POINTS_DEF;
	localparam int FW     = cbkt_pkg::FRAME_WIDTH_DEF;
	localparam int FH     = cbkt_pkg::FRAME_HEIGHT_DEF;
	localparam int NROUND = cbkt_pkg::ROUNDS_DEF;
	localparam int OCW    = cbkt_pkg::OUT_COORD_W;

	typedef struct packed {
		logic           ci;
		logic [OCW-1:0] x;
		logic [OCW-1:0] y;
		logic           trk;
		logic           ovf;
		logic           last;
	} centroid_t;

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [cbkt_pkg::CFG_AW-1:0] paddr = '0;
	logic [cbkt_pkg::CFG_DW-1:0] pwdata = '0;
	logic [cbkt_pkg::CFG_DW-1:0] prdata;
	logic pready;
	logic in_valid = 0;
	logic in_stall;
	logic [cbkt_pkg::PIX_W-1:0] pixel_hue = '0, pixel_sat = '0, pixel_val = '0;
	logic frame_end = 0;
	logic out_valid;
	logic out_stall = 0;
	logic cluster_index;
	logic [OCW-1:0] centroid_x, centroid_y;
	logic tracked, overflowed, last_result;

	color_blob_kmeans_tracker_core DUT (.*);

	initial forever #6 clk = ~clk;

	// predictor state
	logic [cbkt_pkg::PIX_W-1:0] thr [6];
	int pt_col [NPTS];
	int pt_row [NPTS];
	int pt_grp [NPTS];
	int pt_cnt, col_ctr, row_ctr;
	int mx [K], my [K], pmx [K], pmy [K], hx [K], hy [K];
	bit ovf_flag;
	centroid_t centroid_q [$];

	int errors = 0;
	int hold_cycles = 0;
	bit gaps_on = 1;
	int burst_left = 0;
	int pixels_sent = 0;

	function automatic longint sq(int a, int b);
		longint d;
		d = a - b;
		return d * d;
	endfunction

	function automatic bit near(int a, int b);
		return (a > b ? a - b : b - a) < cbkt_pkg::GATE_LIMIT;
	endfunction

	function automatic void cluster_points();
		longint sx, sy, n, d, bd;
		int best;
		for (int i = 0; i < pt_cnt; i++) pt_grp[i] = i % K;
		for (int r = 0; r < NROUND; r++) begin
			for (int j = 0; j < K; j++) begin
				sx = 0; sy = 0; n = 0;
				for (int i = 0; i < pt_cnt; i++)
					if (pt_grp[i] == j) begin
						n++; sx += pt_col[i]; sy += pt_row[i];
					end
				if (n > 0) begin
					mx[j] = int'(sx / n);
					my[j] = int'(sy / n);
				end
			end
			for (int i = 0; i < pt_cnt; i++) begin
				best = 0;
				bd = sq(pt_col[i], mx[0]) + sq(pt_row[i], my[0]);
				for (int j = 1; j < K; j++) begin
					d = sq(pt_col[i], mx[j]) + sq(pt_row[i], my[j]);
					if (d < bd) begin
						bd = d; best = j;
					end
				end
				pt_grp[i] = best;
			end
		end
	endfunction

	function automatic void track_pixel(logic [7:0] h, logic [7:0] s, logic [7:0] v, logic fe);
		bit trk;
		centroid_t c;
		if (h >= thr[cbkt_pkg::REG_HUE_LOW] && h <= thr[cbkt_pkg::REG_HUE_HIGH] &&
		    s >= thr[cbkt_pkg::REG_SAT_LOW] && s <= thr[cbkt_pkg::REG_SAT_HIGH] &&
		    v >= thr[cbkt_pkg::REG_VAL_LOW] && v <= thr[cbkt_pkg::REG_VAL_HIGH]) begin
			if (pt_cnt < NPTS) begin
				pt_col[pt_cnt] = col_ctr;
				pt_row[pt_cnt] = row_ctr;
				pt_cnt++;
			end else
				ovf_flag = 1;
		end
		col_ctr++;
		if (col_ctr >= FW) begin
			col_ctr = 0;
			row_ctr++;
			if (row_ctr >= FH) row_ctr = 0;
		end
		if (!fe) return;
		trk = pt_cnt >= K;
		if (trk) begin
			cluster_points();
			for (int j = 0; j < K; j++) begin
				if (near(mx[j], pmx[j]) && near(my[j], pmy[j])) begin
					hx[j] = mx[j]; hy[j] = my[j];
				end else begin
					hx[j] = pmx[j]; hy[j] = pmy[j];
				end
				pmx[j] = mx[j]; pmy[j] = my[j];
			end
		end
		for (int j = 0; j < K; j++) begin
			c.ci = j[0];
			c.x = hx[j][OCW-1:0];
			c.y = hy[j][OCW-1:0];
			c.trk = trk;
			c.ovf = ovf_flag;
			c.last = (j == K - 1);
			centroid_q.insert(centroid_q.size(), c);
		end
		pt_cnt = 0; ovf_flag = 0; col_ctr = 0; row_ctr = 0;
	endfunction

	task automatic write_thr(cbkt_pkg::reg_idx_t idx, logic [7:0] val);
		@(negedge clk);
		psel = 1; pwrite = 1; penable = 0;
		paddr = cbkt_pkg::CFG_AW'(4 * int'(idx)); pwdata = {24'd0, val};
		@(negedge clk);
		penable = 1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 0; penable = 0; pwrite = 0;
		thr[idx] = val;
	endtask

	task automatic set_window(logic [7:0] hl, hh, sl, sh, vl, vh);
		write_thr(cbkt_pkg::REG_HUE_LOW, hl);  write_thr(cbkt_pkg::REG_HUE_HIGH, hh);
		write_thr(cbkt_pkg::REG_SAT_LOW, sl);  write_thr(cbkt_pkg::REG_SAT_HIGH, sh);
		write_thr(cbkt_pkg::REG_VAL_LOW, vl);  write_thr(cbkt_pkg::REG_VAL_HIGH, vh);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid = 0;
		while (centroid_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic send_pixel(logic [7:0] h, s, v, logic fe);
		int gap;
		if (gaps_on && burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				@(negedge clk);
				in_valid = 0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		if (burst_left > 0) burst_left--;
		@(negedge clk);
		in_valid = 1;
		pixel_hue = h; pixel_sat = s; pixel_val = v; frame_end = fe;
		do @(posedge clk); while (in_stall);
		track_pixel(h, s, v, fe);
		pixels_sent++;
	endtask

	task automatic send_frame(int len, int pct_hit);
		logic [7:0] h, s, v;
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 99) < pct_hit) begin
				h = 8'($urandom_range(thr[cbkt_pkg::REG_HUE_LOW], thr[cbkt_pkg::REG_HUE_HIGH]));
				s = 8'($urandom_range(thr[cbkt_pkg::REG_SAT_LOW], thr[cbkt_pkg::REG_SAT_HIGH]));
				v = 8'($urandom_range(thr[cbkt_pkg::REG_VAL_LOW], thr[cbkt_pkg::REG_VAL_HIGH]));
			end else begin
				h = 8'($urandom); s = 8'($urandom); v = 8'($urandom);
			end
			send_pixel(h, s, v, i == len - 1);
		end
	endtask

	// receiver: stall pattern plus long hold-off on request
	initial begin
		int mode, left;
		mode = 0; left = 0;
		forever begin
			@(negedge clk);
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(50, 400);
			end
			left--;
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_stall = 1;
			end else case (mode)
				0: out_stall = 0;
				1: out_stall = ($urandom_range(0, 99) < 30);
				2: out_stall = ~out_stall;
				default: out_stall = ($urandom_range(0, 99) < 80);
			endcase
		end
	end

	// result checker
	always @(posedge clk) begin
		centroid_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{cluster_index, centroid_x, centroid_y, tracked, overflowed, last_result};
			if (centroid_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected centroid transfer %p", got);
			end else begin
				want = centroid_q.pop_front();
				if (got !== want) begin
					errors++;
					if (errors <= 10) $display("centroid mismatch: expected %p got %p", want, got);
				end
			end
		end
	end

	task automatic test_edge_pixels();
		set_window(8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255);
		send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
		send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
		send_pixel(8'd0, 8'd255, 8'd0, 1'b1);
		for (int f = 0; f < 3; f++) begin
			send_pixel(8'd255, 8'd0, 8'd255, 1'b0);
			send_pixel(8'd1, 8'd1, 8'd1, 1'b0);
			send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
			send_pixel(8'd9, 8'd9, 8'd9, 1'b1);
		end
		drain();
	endtask

	task automatic test_default_window();
		reset_defaults_check();
		set_window(8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0);
		send_frame(6, 50);
		drain();
		set_window(8'd141, 8'd186, 8'd34, 8'd255, 8'd131, 8'd255);
		send_pixel(8'd140, 8'd100, 8'd200, 1'b0);
		send_pixel(8'd141, 8'd34, 8'd131, 1'b0);
		send_pixel(8'd186, 8'd255, 8'd255, 1'b0);
		send_pixel(8'd187, 8'd100, 8'd200, 1'b0);
		send_pixel(8'd160, 8'd33, 8'd200, 1'b0);
		send_pixel(8'd160, 8'd100, 8'd130, 1'b1);
		drain();
	endtask

	task automatic reset_defaults_check();
		send_frame(5, 60);
		drain();
	endtask

	task automatic test_store_full();
		set_window(8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255);
		gaps_on = 0;
		send_frame(NPTS + 3, 100);
		gaps_on = 1;
		drain();
	endtask

	task automatic test_backpressure();
		gaps_on = 0;
		hold_cycles = 3000;
		for (int f = 0; f < 10; f++) send_frame(3, 70);
		gaps_on = 1;
		drain();
	endtask

	task automatic test_random_frames();
		logic [7:0] lo, hi, t;
		int len;
		while (pixels_sent < 1650 + NPTS) begin
			for (int r = 0; r < 6; r++) begin
				lo = 8'($urandom); hi = 8'($urandom);
				if (lo > hi && $urandom_range(0, 9) < 8) begin
					t = lo; lo = hi; hi = t;
				end
				if ($urandom_range(0, 4) == 0) begin
					lo = 0; hi = 255;
				end
				write_thr(cbkt_pkg::reg_idx_t'(2 * (r / 2)), lo);
				write_thr(cbkt_pkg::reg_idx_t'(2 * (r / 2) + 1), hi);
				r++;
			end
			for (int f = 0; f < 8; f++) begin
				gaps_on = $urandom_range(0, 3) != 0;
				len = ($urandom_range(0, 14) == 0) ? $urandom_range(40, 200)
				                                   : $urandom_range(1, 30);
				send_frame(len, $urandom_range(0, 100));
			end
			drain();
		end
	endtask

	initial begin
		thr[cbkt_pkg::REG_HUE_LOW] = cbkt_pkg::HUE_LOW_RST;
		thr[cbkt_pkg::REG_HUE_HIGH] = cbkt_pkg::HUE_HIGH_RST;
		thr[cbkt_pkg::REG_SAT_LOW] = cbkt_pkg::SAT_LOW_RST;
		thr[cbkt_pkg::REG_SAT_HIGH] = cbkt_pkg::SAT_HIGH_RST;
		thr[cbkt_pkg::REG_VAL_LOW] = cbkt_pkg::VAL_LOW_RST;
		thr[cbkt_pkg::REG_VAL_HIGH] = cbkt_pkg::VAL_HIGH_RST;
		pt_cnt = 0; col_ctr = 0; row_ctr = 0; ovf_flag = 0;
		for (int j = 0; j < K; j++) begin
			mx[j] = cbkt_pkg::MEAN_INIT; my[j] = cbkt_pkg::MEAN_INIT;
			pmx[j] = cbkt_pkg::MEAN_INIT; pmy[j] = cbkt_pkg::MEAN_INIT;
			hx[j] = cbkt_pkg::MEAN_INIT; hy[j] = cbkt_pkg::MEAN_INIT;
		end
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		repeat (4) @(posedge clk);
		test_default_window();
		test_edge_pixels();
		test_store_full();
		test_backpressure();
		test_random_frames();
		drain();
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

	initial begin
		#(12 * 4000000);
		$display("tb: errors");
		$finish;
	end

endmodule

`default_nettype wire

[files.f]
rtl/core/cbkt_pkg.sv
rtl/core/cbkt_front.sv
rtl/core/cbkt_fifo.sv
rtl/core/cbkt_div.sv
rtl/core/cbkt_back.sv
rtl/core/color_blob_kmeans_tracker_core.sv
tb/tb.sv
